// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);
// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ant, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ant, cons, msg)
`endif

`endif

// ===== hw/rtl/htffu_pkg.sv =====
// ----------------------------------------------------------------------------
// htffu_pkg
// Shared types and constants of the head/tail frame field unpacker.
// ----------------------------------------------------------------------------
package htffu_pkg;

  // default frame layout
  localparam int FLAG_COUNT_DEF  = 2;
  localparam int CHAR_COUNT_DEF  = 0;
  localparam int INT_COUNT_DEF   = 0;
  localparam int FLOAT_COUNT_DEF = 6;

  // configuration registers
  localparam logic       CFG_HEAD   = 1'b0;
  localparam logic       CFG_TAIL   = 1'b1;
  localparam logic [7:0] HEAD_RESET = 8'd165;
  localparam logic [7:0] TAIL_RESET = 8'd90;

  // bit position of the last flag in a flag byte
  localparam logic [2:0] FLAG_BIT_LAST = 3'h7;

  typedef enum logic [1:0] {
    KIND_FLAG  = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_INT   = 2'd2,
    KIND_FLOAT = 2'd3
  } field_kind_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_EMIT
  } seq_state_t;

  // per-cycle move of the byte cells
  typedef struct packed {
    logic shift1;
    logic shift4;
  } cell_ctl_t;

  // decode of the field being emitted
  typedef struct packed {
    field_kind_t kind;
    logic [3:0]  index;
    logic [2:0]  bit_pos;
    logic        last;
    logic        shift1;
    logic        shift4;
  } emit_ctl_t;

endpackage

// ===== hw/rtl/htffu_byte_if.sv =====
// ----------------------------------------------------------------------------
// htffu_byte_if
// Valid/ready channel carrying one received byte.
// ----------------------------------------------------------------------------
interface htffu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/htffu_field_if.sv =====
// ----------------------------------------------------------------------------
// htffu_field_if
// Valid/ready channel carrying one unpacked frame field.
// ----------------------------------------------------------------------------
interface htffu_field_if;
  logic        valid;
  logic        ready;
  logic [1:0]  field_kind;
  logic [3:0]  field_index;
  logic [31:0] field_value;
  logic        last_field;

  modport source (
    output valid, output field_kind, output field_index, output field_value,
    output last_field, input ready
  );
  modport sink (
    input valid, input field_kind, input field_index, input field_value,
    input last_field, output ready
  );
endinterface

// ===== hw/rtl/htffu_cell.sv =====
// ----------------------------------------------------------------------------
// htffu_cell
// One byte cell of the frame window; loads from the neighbor one or four up.
// ----------------------------------------------------------------------------
module htffu_cell import htffu_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic [7:0] next1,
  input  logic [7:0] next4,
  output logic [7:0] data
);

  // move by a word while draining integers and floats, by one byte on shift1, else hold
  always_ff @(posedge clk) begin
    if (ctl.shift4) begin
      data <= next4;
    end else if (ctl.shift1) begin
      data <= next1;
    end
  end

endmodule

// ===== hw/rtl/htffu_seq.sv =====
// ----------------------------------------------------------------------------
// htffu_seq
// Field sequencer: walks the fields of a matched frame, one per advance.
// ----------------------------------------------------------------------------
module htffu_seq import htffu_pkg::*; #(
  parameter int FLAG_COUNT  = FLAG_COUNT_DEF,
  parameter int CHAR_COUNT  = CHAR_COUNT_DEF,
  parameter int INT_COUNT   = INT_COUNT_DEF,
  parameter int FLOAT_COUNT = FLOAT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      advance,
  output logic      busy,
  output emit_ctl_t ctl
);

  localparam int NUM_FIELDS = FLAG_COUNT + CHAR_COUNT + INT_COUNT + FLOAT_COUNT;
  localparam int CW         = (NUM_FIELDS > 0) ? $clog2(NUM_FIELDS + 1) : 1;
  localparam logic [CW-1:0] CHAR_BASE  = CW'(FLAG_COUNT);
  localparam logic [CW-1:0] INT_BASE   = CW'(FLAG_COUNT + CHAR_COUNT);
  localparam logic [CW-1:0] FLOAT_BASE = CW'(FLAG_COUNT + CHAR_COUNT + INT_COUNT);
  localparam logic [CW-1:0] LAST_FLAG  = CW'(FLAG_COUNT - 1);
  localparam logic [CW-1:0] LAST_FIELD = CW'(NUM_FIELDS - 1);

  seq_state_t    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] rel;

  // state and field counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // decode the current field
  always_comb begin
    ctl = '0;
    priority if (cnt < CHAR_BASE) begin
      rel        = cnt;
      ctl.kind   = KIND_FLAG;
    end else if (cnt < INT_BASE) begin
      rel        = cnt - CHAR_BASE;
      ctl.kind   = KIND_CHAR;
    end else if (cnt < FLOAT_BASE) begin
      rel        = cnt - INT_BASE;
      ctl.kind   = KIND_INT;
    end else begin
      rel        = cnt - FLOAT_BASE;
      ctl.kind   = KIND_FLOAT;
    end
    ctl.index   = 4'(rel);
    ctl.bit_pos = 3'(rel);
    ctl.last    = (cnt == LAST_FIELD);
    unique case (ctl.kind)
      KIND_FLAG: begin
        // leave the flag byte after its top bit or after the last flag
        ctl.shift1 = (ctl.bit_pos == FLAG_BIT_LAST) || (cnt == LAST_FLAG);
      end
      KIND_CHAR: begin
        ctl.shift1 = 1'b1;
      end
      default: begin
        ctl.shift4 = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_EMIT;
          cnt_next   = '0;
        end
      end
      SEQ_EMIT: begin
        if (advance) begin
          if (ctl.last) begin
            state_next = SEQ_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  assign busy = (state == SEQ_EMIT);

endmodule

// ===== hw/rtl/head_tail_frame_field_unpacker.sv =====
// ----------------------------------------------------------------------------
// head_tail_frame_field_unpacker
// Collecting, one byte is taken per cycle while not emitting; the frame check
// runs on the closing byte. A match starts the single field sequencer; its state
// register and then the output register put out the first field, then one field per
// cycle while the receiver is ready. No byte is taken while the fields of a match are
// emitted. Reset clears the fill count and valid, loads head 0xA5 and tail 0x5A.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module head_tail_frame_field_unpacker import htffu_pkg::*; #(
  parameter int FLAG_COUNT  = FLAG_COUNT_DEF,
  parameter int CHAR_COUNT  = CHAR_COUNT_DEF,
  parameter int INT_COUNT   = INT_COUNT_DEF,
  parameter int FLOAT_COUNT = FLOAT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  htffu_byte_if.sink    rx,
  htffu_field_if.source fields
);

  localparam int FLAG_BYTES = (FLAG_COUNT + 7) / 8;
  localparam int FRAME_LEN  = 2 + FLAG_BYTES + CHAR_COUNT + 4 * INT_COUNT + 4 * FLOAT_COUNT;
  localparam int NUM_FIELDS = FLAG_COUNT + CHAR_COUNT + INT_COUNT + FLOAT_COUNT;
  localparam int FW         = $clog2(FRAME_LEN);
  localparam logic [FW-1:0] FILL_FULL = FW'(FRAME_LEN - 1);

  logic [7:0]    head_byte, tail_byte;
  logic [FW-1:0] fill, fill_next;
  logic [7:0]    win [FRAME_LEN + 4];
  logic [7:0]    tail_in;
  logic          in_fire, match, load, busy;
  cell_ctl_t     cell_ctl;
  emit_ctl_t     ectl;
  logic [31:0]   value;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= HEAD_RESET;
      tail_byte <= TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAD: head_byte <= cfg_data;
        CFG_TAIL: tail_byte <= cfg_data;
        default:  head_byte <= head_byte;
      endcase
    end
  end

  assign rx.ready = !busy;
  assign in_fire  = rx.valid && rx.ready;
  // window after this byte: oldest is cell 1, newest is the incoming byte
  assign match    = (fill == FILL_FULL) && (win[1] == head_byte) && (rx.rx_byte == tail_byte);

  // fill count: empty on a match, hold full on a mismatch
  always_comb begin
    fill_next = fill;
    if (in_fire) begin
      if (match) begin
        fill_next = '0;
      end else if (fill != FILL_FULL) begin
        fill_next = fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // field sequencer
  htffu_seq #(
    .FLAG_COUNT  (FLAG_COUNT),
    .CHAR_COUNT  (CHAR_COUNT),
    .INT_COUNT   (INT_COUNT),
    .FLOAT_COUNT (FLOAT_COUNT)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (in_fire && match && (NUM_FIELDS > 0)),
    .advance (load),
    .busy    (busy),
    .ctl     (ectl)
  );

  assign load = busy && (!fields.valid || fields.ready);

  // cell moves: shift in on a byte transfer, drain while emitting
  always_comb begin
    cell_ctl        = '0;
    cell_ctl.shift1 = in_fire || (load && ectl.shift1);
    cell_ctl.shift4 = load && ectl.shift4;
  end

  assign tail_in = in_fire ? rx.rx_byte : 8'h00;

  // row of byte cells, oldest at cell 0
  for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
    logic [7:0] n1;
    if (i == FRAME_LEN - 1) begin : g_end
      assign n1 = tail_in;
    end else begin : g_mid
      assign n1 = win[i + 1];
    end
    htffu_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl),
      .next1 (n1),
      .next4 (win[i + 4]),
      .data  (win[i])
    );
  end

  for (genvar i = FRAME_LEN; i < FRAME_LEN + 4; i++) begin : g_pad
    assign win[i] = 8'h00;
  end

  // field value from the front of the window
  always_comb begin
    unique case (ectl.kind)
      KIND_FLAG: value = {31'd0, win[1][ectl.bit_pos]};
      KIND_CHAR: value = {24'd0, win[1]};
      default:   value = {win[4], win[3], win[2], win[1]};
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      fields.valid <= 1'b0;
    end else if (load) begin
      fields.valid <= 1'b1;
    end else if (fields.ready) begin
      fields.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fields.field_kind  <= ectl.kind;
      fields.field_index <= ectl.index;
      fields.field_value <= value;
      fields.last_field  <= ectl.last;
    end
  end

  `ASSERT_IMPL(a_fill_range, clk, rst, 1'b1, fill <= FILL_FULL, "fill count beyond frame")
  `ASSERT_NEXT(a_match_starts, clk, rst, in_fire && match && (NUM_FIELDS > 0), busy, "match without emission")
  `ASSERT_NEXT(a_last_ends, clk, rst, load && ectl.last, !busy && fields.valid, "emission not closed after last field")

endmodule
